>>> rtl/lru_page_replacement_list_defines.svh
// Assertion macros used by the checker file of the page replacement list
`ifndef LRU_PAGE_REPLACEMENT_LIST_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_LIST_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed: same-cycle implication violated");

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed: next-cycle implication violated");

`endif

>>> rtl/lprl_pkg.sv
// Shared types and constants of the page replacement list
package lprl_pkg;

    localparam int FRAMES_DEF  = 16;
    localparam int PAGE_W      = 20;
    localparam int FUNC_W      = 2;
    localparam int STAT_W      = 2;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 2'd0,
        FN_ACCESS = 2'd1,
        FN_TICK   = 2'd2,
        FN_VICTIM = 2'd3
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE   = 2'd0,
        ST_VICTIM = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef struct packed {
        func_t             func;
        logic [PAGE_W-1:0] page;
    } cmd_t;

    typedef struct packed {
        logic vld;
        cmd_t cmd;
    } q_out_t;

endpackage

>>> rtl/lprl_front.sv
// Command intake: accept, classify and queue transactions for the list engine
module lprl_front import lprl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [FUNC_W-1:0] func,
    input  logic [PAGE_W-1:0] page_id,
    input  logic              pop,
    output logic              busy,
    output q_out_t            q_out
);

    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    cmd_t            q_reg [QUEUE_DEPTH];
    logic [QW-1:0]   wr_ptr_reg;
    logic [QW-1:0]   wr_ptr_next;
    logic [QW-1:0]   rd_ptr_reg;
    logic [QW-1:0]   rd_ptr_next;
    logic [FW-1:0]   fill_reg;
    logic [FW-1:0]   fill_next;
    logic            push;
    logic            pop_ok;
    func_t           func_in;
    cmd_t            cmd_in;

    always_comb
    begin
        func_in     = func_t'(func);
        cmd_in.func = func_in;
        unique case (func_in)
            FN_INSERT, FN_ACCESS: cmd_in.page = page_id;
            FN_TICK, FN_VICTIM:   cmd_in.page = '0;
        endcase
    end

    assign busy   = (fill_reg == FW'(QUEUE_DEPTH));
    assign push   = start && !busy;
    assign pop_ok = pop && (fill_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QW'(1);
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QW'(1);
        end
        fill_next = fill_reg + FW'(push) - FW'(pop_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    assign q_out.vld = (fill_reg != '0);
    assign q_out.cmd = q_reg[rd_ptr_reg];

endmodule

>>> rtl/lprl_back.sv
// List engine: ping-pong page memory walked one entry per cycle
module lprl_back import lprl_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  q_out_t            q_in,
    output logic              pop,
    output logic              done,
    output status_t           status,
    output logic [PAGE_W-1:0] victim_page
);

    localparam int IW = $clog2(FRAMES);
    localparam int CW = $clog2(FRAMES + 1);
    localparam int DW = PAGE_W + 1;
    localparam logic [CW-1:0] FULL_CNT = CW'(FRAMES);
    localparam logic [IW:0]   FRAMES_X = (IW + 1)'(FRAMES);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_WALK = 3'b010,
        B_FIN  = 3'b100
    } bstate_t;

    logic [DW-1:0]     mem [2][FRAMES];

    bstate_t           state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic              bank_reg, bank_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     hot_reg, hot_next;
    logic              iss_on_reg, iss_on_next;
    logic [IW-1:0]     iss_idx_reg, iss_idx_next;
    logic              rd_vld_reg, rd_vld_next;
    logic              rd_last_reg, rd_last_next;
    logic [IW-1:0]     rd_pos_reg, rd_pos_next;
    logic [DW-1:0]     rd_data_reg;
    logic              hit_reg, hit_next;
    logic              hit_bit_reg, hit_bit_next;
    logic [CW-1:0]     hptr_reg, hptr_next;
    logic [CW-1:0]     cptr_reg, cptr_next;
    logic [PAGE_W-1:0] vic_page_reg, vic_page_next;
    logic              vic_bit_reg, vic_bit_next;
    logic              done_reg, done_next;
    status_t           status_reg, status_next;
    logic [PAGE_W-1:0] victim_reg, victim_next;

    logic              we;
    logic              wbank;
    logic [IW-1:0]     widx;
    logic [DW-1:0]     wdata;
    logic              re;

    logic [CW-1:0]     cnt_m1;
    logic [IW-1:0]     last_idx;
    logic [CW-1:0]     hptr_m1;
    logic [IW:0]       pos_inc;
    logic              in_range;
    logic              d_bit;
    logic [PAGE_W-1:0] d_page;
    logic              d_hit;

    assign cnt_m1   = cnt_reg - CW'(1);
    assign last_idx = cnt_m1[IW-1:0];
    assign hptr_m1  = hptr_reg - CW'(1);
    assign pos_inc  = {1'b0, rd_pos_reg} + (IW + 1)'(1);
    assign in_range = (pos_inc < FRAMES_X);
    assign d_bit    = rd_data_reg[PAGE_W];
    assign d_page   = rd_data_reg[PAGE_W-1:0];
    assign d_hit    = (d_page == cmd_reg.page);

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        bank_next     = bank_reg;
        cnt_next      = cnt_reg;
        hot_next      = hot_reg;
        iss_on_next   = iss_on_reg;
        iss_idx_next  = iss_idx_reg;
        rd_vld_next   = 1'b0;
        rd_last_next  = rd_last_reg;
        rd_pos_next   = rd_pos_reg;
        hit_next      = hit_reg;
        hit_bit_next  = hit_bit_reg;
        hptr_next     = hptr_reg;
        cptr_next     = cptr_reg;
        vic_page_next = vic_page_reg;
        vic_bit_next  = vic_bit_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        victim_next   = victim_reg;
        we            = 1'b0;
        wbank         = bank_reg;
        widx          = '0;
        wdata         = '0;
        re            = 1'b0;
        pop           = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_in.vld)
                begin
                    pop          = 1'b1;
                    cmd_next     = q_in.cmd;
                    hit_next     = 1'b0;
                    hit_bit_next = 1'b0;
                    hptr_next    = hot_reg;
                    cptr_next    = hot_reg;
                    if (cnt_reg == '0)
                    begin
                        state_next = B_FIN;
                    end
                    else
                    begin
                        state_next   = B_WALK;
                        iss_on_next  = 1'b1;
                        iss_idx_next = (q_in.cmd.func == FN_VICTIM) ? last_idx : '0;
                    end
                end
            end
            B_WALK:
            begin
                // issue one read per cycle, process its data in the following cycle
                if (iss_on_reg)
                begin
                    re           = 1'b1;
                    rd_vld_next  = 1'b1;
                    rd_pos_next  = iss_idx_reg;
                    rd_last_next = (iss_idx_reg == last_idx);
                    iss_idx_next = iss_idx_reg + IW'(1);
                    if (iss_idx_reg == last_idx)
                    begin
                        iss_on_next = 1'b0;
                    end
                end
                if (rd_vld_reg)
                begin
                    unique case (cmd_reg.func)
                        FN_INSERT:
                        begin
                            if (d_hit)
                            begin
                                hit_next     = 1'b1;
                                hit_bit_next = d_bit;
                            end
                            else if (hit_reg)
                            begin
                                we    = 1'b1;
                                wbank = ~bank_reg;
                                widx  = rd_pos_reg;
                                wdata = rd_data_reg;
                            end
                            else if (in_range)
                            begin
                                we    = 1'b1;
                                wbank = ~bank_reg;
                                widx  = pos_inc[IW-1:0];
                                wdata = rd_data_reg;
                            end
                        end
                        FN_ACCESS:
                        begin
                            if (d_hit)
                            begin
                                we    = 1'b1;
                                wbank = bank_reg;
                                widx  = rd_pos_reg;
                                wdata = {1'b1, d_page};
                                if (!d_bit)
                                begin
                                    hot_next = hot_reg + CW'(1);
                                end
                            end
                        end
                        FN_TICK:
                        begin
                            // accessed pages fill the front from the back end down
                            we    = 1'b1;
                            wbank = ~bank_reg;
                            wdata = {1'b0, d_page};
                            if (d_bit)
                            begin
                                widx      = hptr_m1[IW-1:0];
                                hptr_next = hptr_m1;
                            end
                            else
                            begin
                                widx      = cptr_reg[IW-1:0];
                                cptr_next = cptr_reg + CW'(1);
                            end
                        end
                        FN_VICTIM:
                        begin
                            vic_page_next = d_page;
                            vic_bit_next  = d_bit;
                        end
                    endcase
                    if (rd_last_reg)
                    begin
                        state_next = B_FIN;
                    end
                end
            end
            B_FIN:
            begin
                state_next  = B_IDLE;
                done_next   = 1'b1;
                status_next = ST_DONE;
                victim_next = '0;
                unique case (cmd_reg.func)
                    FN_INSERT:
                    begin
                        if (hit_reg)
                        begin
                            we        = 1'b1;
                            wbank     = ~bank_reg;
                            widx      = '0;
                            wdata     = {hit_bit_reg, cmd_reg.page};
                            bank_next = ~bank_reg;
                        end
                        else if (cnt_reg != FULL_CNT)
                        begin
                            we        = 1'b1;
                            wbank     = ~bank_reg;
                            widx      = '0;
                            wdata     = {1'b0, cmd_reg.page};
                            bank_next = ~bank_reg;
                            cnt_next  = cnt_reg + CW'(1);
                        end
                        else
                        begin
                            status_next = ST_FULL;
                        end
                    end
                    FN_ACCESS:
                    begin
                    end
                    FN_TICK:
                    begin
                        bank_next = ~bank_reg;
                        hot_next  = '0;
                    end
                    FN_VICTIM:
                    begin
                        if (cnt_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            status_next = ST_VICTIM;
                            victim_next = vic_page_reg;
                            cnt_next    = cnt_m1;
                            if (vic_bit_reg)
                            begin
                                hot_next = hot_reg - CW'(1);
                            end
                        end
                    end
                endcase
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            bank_reg    <= 1'b0;
            cnt_reg     <= '0;
            hot_reg     <= '0;
            iss_on_reg  <= 1'b0;
            rd_vld_reg  <= 1'b0;
            rd_last_reg <= 1'b0;
            hit_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bank_reg    <= bank_next;
            cnt_reg     <= cnt_next;
            hot_reg     <= hot_next;
            iss_on_reg  <= iss_on_next;
            rd_vld_reg  <= rd_vld_next;
            rd_last_reg <= rd_last_next;
            hit_reg     <= hit_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        iss_idx_reg  <= iss_idx_next;
        rd_pos_reg   <= rd_pos_next;
        hit_bit_reg  <= hit_bit_next;
        hptr_reg     <= hptr_next;
        cptr_reg     <= cptr_next;
        vic_page_reg <= vic_page_next;
        vic_bit_reg  <= vic_bit_next;
        status_reg   <= status_next;
        victim_reg   <= victim_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wbank][widx] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[bank_reg][iss_idx_reg];
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign victim_page = victim_reg;

endmodule

>>> rtl/lru_page_replacement_list.sv
// Top level of the LRU-approximation page replacement list. A command is taken
// when start is high and busy is low; up to two commands wait in an intake queue,
// and busy is high only while that queue is full. Every command gives exactly one
// result, shown on status and victim_page for one cycle while done is high; the
// receiver must take it then. The list lives in a two-bank page memory with one
// read and one write port, and the engine walks it one entry per cycle: insert,
// access and tick read every entry, a victim request reads only the last one,
// and any command on an empty list skips the walk.
module lru_page_replacement_list import lprl_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [FUNC_W-1:0] func,
    input  logic [PAGE_W-1:0] page_id,
    output logic              done,
    output logic [STAT_W-1:0] status,
    output logic [PAGE_W-1:0] victim_page
);

    q_out_t  q_out;
    logic    pop;
    status_t status_int;

    lprl_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .func    (func),
        .page_id (page_id),
        .pop     (pop),
        .busy    (busy),
        .q_out   (q_out)
    );

    lprl_back #(
        .FRAMES (FRAMES)
    ) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_in        (q_out),
        .pop         (pop),
        .done        (done),
        .status      (status_int),
        .victim_page (victim_page)
    );

    assign status = status_int;

endmodule

>>> rtl/lprl_checker.sv
// Port-level checker for the page replacement list and its bind
`include "lru_page_replacement_list_defines.svh"

module lprl_checker import lprl_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic [FUNC_W-1:0] func,
    input logic [PAGE_W-1:0] page_id,
    input logic              done,
    input logic [STAT_W-1:0] status,
    input logic [PAGE_W-1:0] victim_page
);

    `ASSERT_IMPLY(a_victim_zero, clk, rst_n, done && (status != ST_VICTIM), victim_page == '0)
    `ASSERT_NEXT(a_done_gap, clk, rst_n, done, !done)
    `ASSERT_IMPLY(a_busy_after_accept, clk, rst_n, $rose(busy), $past(start))

endmodule

bind lru_page_replacement_list lprl_checker u_lprl_checker (.*);
